>>> src/lcr_pkg.sv
`default_nettype none
package lcr_pkg;
	localparam int DEF_MAX_ROWS = 128;
	localparam int DEF_MAX_COLS = 128;
	localparam int CFG_W = 8;
	localparam int AREA_W = 15;
	localparam int AREA_MAX = 32767;
	localparam int CFG_AW = 3;
	localparam int APB_DW = 32;
	// register index, taken from paddr[2]
	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;
endpackage
`default_nettype wire

>>> src/lcr_cfg_regs.sv
`default_nettype none
module lcr_cfg_regs #(
	parameter int MAX_ROWS = lcr_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = lcr_pkg::DEF_MAX_COLS,
	parameter int RW = $clog2(MAX_ROWS + 1),
	parameter int CW = $clog2(MAX_COLS + 1)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lcr_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [lcr_pkg::APB_DW-1:0]  pwdata,
	output logic      [lcr_pkg::APB_DW-1:0]  prdata,
	output logic                             pready,
	output logic      [RW-1:0]               rows_eff,
	output logic      [CW-1:0]               cols_eff
);
	import lcr_pkg::*;

	logic [CFG_W-1:0] row_count_q;
	logic [CFG_W-1:0] col_count_q;
	logic             wr_en;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= CFG_W'(DEF_MAX_ROWS);
			col_count_q <= CFG_W'(DEF_MAX_COLS);
		end else if (wr_en) begin
			case (reg_sel)
				REG_ROW_COUNT: row_count_q <= pwdata[CFG_W-1:0];
				REG_COL_COUNT: col_count_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_ROW_COUNT: prdata = APB_DW'(row_count_q);
			REG_COL_COUNT: prdata = APB_DW'(col_count_q);
			default:       prdata = '0;
		endcase
	end

	// zero counts as one, oversize counts as the maximum
	always_comb begin
		if (row_count_q == '0)
			rows_eff = RW'(1);
		else if (32'(row_count_q) > 32'(MAX_ROWS))
			rows_eff = RW'(MAX_ROWS);
		else
			rows_eff = RW'(row_count_q);
		if (col_count_q == '0)
			cols_eff = CW'(1);
		else if (32'(col_count_q) > 32'(MAX_COLS))
			cols_eff = CW'(MAX_COLS);
		else
			cols_eff = CW'(col_count_q);
	end
endmodule
`default_nettype wire

>>> src/largest_checkerboard_rectangle_unit.sv
`default_nettype none
// Largest chessboard-pattern rectangle in a binary matrix.
// Input channel: one cell per transfer (cell_value, last_cell), row-major,
// in_valid / in_stall. One cell is taken per cycle while the unit is loading.
// The transfer that carries last_cell starts the solve; in_stall stays high
// until the solve is done and the result sits in the output register.
// Output channel: one transfer (largest_area) per matrix, out_valid /
// out_stall. The result register holds while the receiver stalls, and the
// next matrix may already load behind it; a new result waits for the old one.
// After the last cell: the vertical-run sweep (read, then write back, per
// cell), then per row two stack passes, right then left, each reading,
// comparing and pushing per column, with a stack read per pop. The matrix
// memory is single-port.
// Configuration: APB, row_count at 0x0, col_count at 0x4; write only while
// idle. Reset empties the unit, sets both counts to their maximum and clears
// the load position and the best area. The matrix memory is not cleared:
// the sweep rewrites every run entry before it is read.
module largest_checkerboard_rectangle_unit #(
	parameter int MAX_ROWS = lcr_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = lcr_pkg::DEF_MAX_COLS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        cell_value,
	input  wire logic                        last_cell,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [lcr_pkg::AREA_W-1:0]  largest_area,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lcr_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [lcr_pkg::APB_DW-1:0]  pwdata,
	output logic      [lcr_pkg::APB_DW-1:0]  prdata,
	output logic                             pready
);
	import lcr_pkg::*;

	localparam int RW    = $clog2(MAX_ROWS + 1);               // row values 0..rows
	localparam int CW    = $clog2(MAX_COLS + 1);               // column bounds 0..cols
	localparam int IW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = $clog2(DEPTH + 1);
	localparam int PRW   = RW + CW;

	typedef enum logic [2:0] {
		S_IDLE, S_P1_RD, S_P1_WR, S_RD, S_CMP, S_POP, S_TOP, S_FIN
	} state_t;

	typedef struct packed {
		logic [IW-1:0] idx;
		logic [RW-1:0] re;
		logic          cval;
		logic [CW-1:0] rgt;
	} stk_ent_t;

	logic [RW-1:0] rows_eff;
	logic [CW-1:0] cols_eff;

	lcr_cfg_regs #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS),
		.RW(RW),
		.CW(CW)
	) u_cfg (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.rows_eff(rows_eff), .cols_eff(cols_eff)
	);

	// matrix memory: {cell, run end row}
	logic [RW:0]    mat_mem [DEPTH];
	logic [RW:0]    mrd_q;
	logic [AW-1:0]  mat_addr;
	logic           mat_we;
	logic [RW:0]    mat_wdata;

	logic [CW-1:0]  right_mem [MAX_COLS];
	logic [CW-1:0]  rrd_q;
	logic           right_we;

	stk_ent_t       stk_mem [MAX_COLS];
	stk_ent_t       srd_q;
	logic           stk_we;
	logic [IW-1:0]  stk_raddr;
	logic [IW-1:0]  stk_waddr;

	state_t         state_q;
	logic [PW-1:0]  pos_q;
	logic [PW-1:0]  total;
	logic [AW-1:0]  addr_q;
	logic [AW-1:0]  base_q;
	logic [IW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic           below_cell_q;
	logic [RW-1:0]  below_re_q;
	logic [IW-1:0]  jx_q;
	logic           pass_left_q;
	logic           end_q;
	logic           popall_q;
	logic [CW-1:0]  bnd_q;
	logic [CW-1:0]  sp_q;
	stk_ent_t       top_q;
	stk_ent_t       cur_q;
	logic [PRW-1:0] prod_q;
	logic           prod_v_q;
	logic [PRW-1:0] best_q;
	logic           out_valid_q;
	logic [AREA_W-1:0] area_q;

	logic           in_xfer;
	logic           p1_cell;
	logic [RW-1:0]  p1_re;
	logic           do_pop;
	logic [AW-1:0]  scan_addr;
	logic           fin_go;

	assign total     = PW'(32'(rows_eff) * 32'(cols_eff));
	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign largest_area = area_q;
	// result register free or emptied this cycle
	assign fin_go    = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	assign p1_cell = mrd_q[RW];
	always_comb begin
		if (row_q == rows_eff - RW'(1))
			p1_re = rows_eff;
		else if (p1_cell == below_cell_q)
			p1_re = row_q + RW'(1);
		else
			p1_re = below_re_q;
	end

	assign scan_addr = base_q + AW'(jx_q);
	assign do_pop    = (sp_q != '0) && (popall_q || (cur_q.re < top_q.re));
	assign stk_raddr = IW'(sp_q - CW'(2));
	assign stk_waddr = IW'(sp_q - CW'(1));

	always_comb begin
		mat_we    = 1'b0;
		mat_wdata = {cell_value, RW'(0)};
		mat_addr  = scan_addr;
		case (state_q)
			S_IDLE: begin
				mat_addr = AW'(pos_q);
				mat_we   = in_xfer && (pos_q < total);
			end
			S_P1_RD: mat_addr = addr_q;
			S_P1_WR: begin
				mat_addr  = addr_q;
				mat_we    = 1'b1;
				mat_wdata = {p1_cell, p1_re};
			end
			default: mat_addr = scan_addr;
		endcase
	end

	assign right_we = (state_q == S_POP) && do_pop && !pass_left_q;
	assign stk_we   = (state_q == S_POP) && !do_pop && !end_q && (sp_q != '0);

	always_ff @(posedge clk) begin
		if (mat_we)
			mat_mem[mat_addr] <= mat_wdata;
		mrd_q <= mat_mem[mat_addr];
	end

	always_ff @(posedge clk) begin
		if (right_we)
			right_mem[top_q.idx] <= bnd_q;
		rrd_q <= right_mem[jx_q];
	end

	always_ff @(posedge clk) begin
		if (stk_we)
			stk_mem[stk_waddr] <= top_q;
		srd_q <= stk_mem[stk_raddr];
	end

	// product of height and width, registered and compared in the following cycle
	always_ff @(posedge clk) begin
		prod_q <= PRW'(top_q.re - row_q) * PRW'(top_q.rgt - bnd_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pos_q        <= '0;
			addr_q       <= '0;
			base_q       <= '0;
			col_q        <= '0;
			row_q        <= '0;
			below_cell_q <= 1'b0;
			below_re_q   <= '0;
			jx_q         <= '0;
			pass_left_q  <= 1'b0;
			end_q        <= 1'b0;
			popall_q     <= 1'b0;
			bnd_q        <= '0;
			sp_q         <= '0;
			top_q        <= '0;
			cur_q        <= '0;
			prod_v_q     <= 1'b0;
			best_q       <= '0;
			out_valid_q  <= 1'b0;
			area_q       <= '0;
		end else begin
			prod_v_q <= (state_q == S_POP) && do_pop && pass_left_q;
			if (fin_go)
				best_q <= '0;
			else if (prod_v_q && (prod_q > best_q))
				best_q <= prod_q;
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (pos_q < total)
							pos_q <= pos_q + PW'(1);
						if (last_cell) begin
							col_q   <= '0;
							row_q   <= rows_eff - RW'(1);
							addr_q  <= AW'(total - PW'(cols_eff));
							state_q <= S_P1_RD;
						end
					end
				end
				S_P1_RD: state_q <= S_P1_WR;
				S_P1_WR: begin
					below_cell_q <= p1_cell;
					below_re_q   <= p1_re;
					if (row_q == '0) begin
						if (CW'(col_q) == cols_eff - CW'(1)) begin
							// sweep done: first row, right pass
							row_q       <= '0;
							base_q      <= '0;
							jx_q        <= '0;
							pass_left_q <= 1'b0;
							end_q       <= 1'b0;
							sp_q        <= '0;
							state_q     <= S_RD;
						end else begin
							col_q   <= col_q + IW'(1);
							row_q   <= rows_eff - RW'(1);
							addr_q  <= AW'(total - PW'(cols_eff)) + AW'(col_q) + AW'(1);
							state_q <= S_P1_RD;
						end
					end else begin
						row_q   <= row_q - RW'(1);
						addr_q  <= addr_q - AW'(cols_eff);
						state_q <= S_P1_RD;
					end
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					cur_q.idx  <= jx_q;
					cur_q.cval <= mrd_q[RW];
					cur_q.re   <= mrd_q[RW-1:0];
					cur_q.rgt  <= rrd_q;
					popall_q   <= (sp_q != '0) && (mrd_q[RW] == top_q.cval);
					bnd_q      <= pass_left_q ? (CW'(jx_q) + CW'(1)) : CW'(jx_q);
					state_q    <= S_POP;
				end
				S_POP: begin
					if (do_pop) begin
						sp_q <= sp_q - CW'(1);
						if (sp_q >= CW'(2))
							state_q <= S_TOP;
					end else if (end_q) begin
						end_q <= 1'b0;
						sp_q  <= '0;
						if (!pass_left_q) begin
							pass_left_q <= 1'b1;
							jx_q        <= IW'(cols_eff - CW'(1));
							state_q     <= S_RD;
						end else if (row_q == rows_eff - RW'(1)) begin
							state_q <= S_FIN;
						end else begin
							pass_left_q <= 1'b0;
							row_q       <= row_q + RW'(1);
							base_q      <= base_q + AW'(cols_eff);
							jx_q        <= '0;
							state_q     <= S_RD;
						end
					end else begin
						top_q <= cur_q;
						sp_q  <= sp_q + CW'(1);
						if (!pass_left_q) begin
							if (CW'(jx_q) == cols_eff - CW'(1)) begin
								end_q    <= 1'b1;
								popall_q <= 1'b1;
								bnd_q    <= cols_eff;
							end else begin
								jx_q    <= jx_q + IW'(1);
								state_q <= S_RD;
							end
						end else begin
							if (jx_q == '0) begin
								end_q    <= 1'b1;
								popall_q <= 1'b1;
								bnd_q    <= '0;
							end else begin
								jx_q    <= jx_q - IW'(1);
								state_q <= S_RD;
							end
						end
					end
				end
				S_TOP: begin
					top_q   <= srd_q;
					state_q <= S_POP;
				end
				S_FIN: begin
					if (fin_go) begin
						area_q <= (32'(best_q) > 32'(AREA_MAX)) ?
							AREA_W'(AREA_MAX) : AREA_W'(best_q);
						pos_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= cols_eff)
		else $error("stack depth exceeds column count");

	a_prod_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		prod_v_q |-> ($past(state_q) == S_POP) && $past(pass_left_q))
		else $error("area product without a left-pass pop");

	a_p1_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_P1_WR) |-> (row_q < rows_eff))
		else $error("run sweep row out of range");

	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FIN) && (!out_valid_q || !out_stall)) |=>
			(pos_q == '0) && out_valid_q && (state_q == S_IDLE))
		else $error("result not loaded or load position not cleared");
endmodule
`default_nettype wire

>>> tb/largest_checkerboard_rectangle_checker.sv
`default_nettype none
module largest_checkerboard_rectangle_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic                        in_stall,
	input  wire logic                        cell_value,
	input  wire logic                        last_cell,
	input  wire logic                        out_valid,
	input  wire logic                        out_stall,
	input  wire logic [lcr_pkg::AREA_W-1:0]  largest_area,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic                        pready,
	input  wire logic [lcr_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [lcr_pkg::APB_DW-1:0]  pwdata,
	output int                               errors,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS_MAX = lcr_pkg::DEF_MAX_ROWS;
	localparam int COLS_MAX = lcr_pkg::DEF_MAX_COLS;

	bit                          cells [ROWS_MAX*COLS_MAX];
	int                          run_end [ROWS_MAX*COLS_MAX];
	int                          lb [COLS_MAX];
	int                          rb [COLS_MAX];
	int                          stk [COLS_MAX];
	logic [lcr_pkg::CFG_W-1:0]   row_reg;
	logic [lcr_pkg::CFG_W-1:0]   col_reg;
	int                          load_pos;
	logic [lcr_pkg::AREA_W-1:0]  expected_areas [$];

	function automatic int clamp_dim(logic [lcr_pkg::CFG_W-1:0] v, int maxv);
		if (v == 0) return 1;
		if (int'(v) > maxv) return maxv;
		return int'(v);
	endfunction

	// vertical runs, then left/right bound stacks per row
	function automatic int largest_board(int r, int c);
		int i, j, sp, up, dn, base, top, cc, h, w, a, best;
		best = 0;
		for (j = 0; j < c; j++) begin
			run_end[(r-1)*c + j] = r;
			for (i = r-1; i > 0; i--) begin
				up = (i-1)*c + j;
				dn = i*c + j;
				run_end[up] = (cells[up] == cells[dn]) ? i : run_end[dn];
			end
		end
		for (i = 0; i < r; i++) begin
			base = i*c;
			for (j = 0; j < c; j++) begin
				lb[j] = -1;
				rb[j] = c;
			end
			sp = 0;
			stk[sp] = 0;
			sp++;
			for (j = 1; j < c; j++) begin
				top = stk[sp-1];
				if (cells[base+j] == cells[base+top]) begin
					while (sp > 0) begin sp--; rb[stk[sp]] = j; end
				end else begin
					while (sp > 0 && run_end[base+j] < run_end[base+stk[sp-1]]) begin
						sp--;
						rb[stk[sp]] = j;
					end
				end
				stk[sp] = j;
				sp++;
			end
			sp = 0;
			stk[sp] = c-1;
			sp++;
			for (j = c-1; j > 0; j--) begin
				cc = j-1;
				top = stk[sp-1];
				if (cells[base+cc] == cells[base+top]) begin
					while (sp > 0) begin sp--; lb[stk[sp]] = cc; end
				end else begin
					while (sp > 0 && run_end[base+cc] < run_end[base+stk[sp-1]]) begin
						sp--;
						lb[stk[sp]] = cc;
					end
				end
				stk[sp] = cc;
				sp++;
			end
			for (j = 0; j < c; j++) begin
				h = run_end[base+j] - i;
				w = rb[j] - lb[j] - 1;
				a = h*w;
				if (a > best) best = a;
			end
		end
		if (best > lcr_pkg::AREA_MAX) best = lcr_pkg::AREA_MAX;
		return best;
	endfunction

	task automatic report(string what, int got, int want);
		$display("tb: mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
		errors++;
	endtask

	assign pending = expected_areas.size();

	always @(posedge clk or negedge arst_n) begin
		int total;
		logic [lcr_pkg::AREA_W-1:0] want;
		if (!arst_n) begin
			row_reg = 8'd128;
			col_reg = 8'd128;
			load_pos = 0;
			expected_areas.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == lcr_pkg::REG_ROW_COUNT) row_reg = pwdata[7:0];
				else col_reg = pwdata[7:0];
			end
			if (in_valid && !in_stall) begin
				total = clamp_dim(row_reg, ROWS_MAX) * clamp_dim(col_reg, COLS_MAX);
				if (load_pos < total) begin
					cells[load_pos] = cell_value;
					load_pos++;
				end
				if (last_cell) begin
					expected_areas.push_back(
						lcr_pkg::AREA_W'(largest_board(clamp_dim(row_reg, ROWS_MAX),
							clamp_dim(col_reg, COLS_MAX))));
					load_pos = 0;
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_areas.size() == 0) begin
					report("result with none expected, area", largest_area, -1);
				end else begin
					want = expected_areas.pop_front();
					if (largest_area !== want) report("largest_area", largest_area, want);
				end
			end
		end
	end

	initial errors = 0;
endmodule
`default_nettype wire

>>> tb/largest_checkerboard_rectangle_unit_test.sv
`default_nettype none
module largest_checkerboard_rectangle_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	// run length and watchdog
	localparam int ITEM_TARGET = 1900;
	localparam int IDLE_LIMIT  = 100000;
	localparam int LONG_HOLD   = 3000;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         cell_value = 1'b0;
	logic                         last_cell = 1'b0;
	logic                         out_stall = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [lcr_pkg::CFG_AW-1:0]   paddr = '0;
	logic [lcr_pkg::APB_DW-1:0]   pwdata = '0;
	wire logic                    in_stall;
	wire logic                    out_valid;
	wire logic [lcr_pkg::AREA_W-1:0] largest_area;
	wire logic [lcr_pkg::APB_DW-1:0] prdata;
	wire logic                    pready;
	int                           errors;
	int                           pending;

	// stimulus bookkeeping
	int  cells_sent = 0;
	int  matrices = 0;
	int  surplus_runs = 0;
	int  early_runs = 0;
	int  reg_writes = 0;
	int  filled = 0;          // linear entries of the cell store written since reset
	int  burst_left = 0;
	int  rows_eff = 128;
	int  cols_eff = 128;
	int  hold_token = 0;
	int  idle_cycles = 0;

	always #10 clk = ~clk;

	largest_checkerboard_rectangle_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cell_value(cell_value), .last_cell(last_cell),
		.out_valid(out_valid), .out_stall(out_stall), .largest_area(largest_area),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	largest_checkerboard_rectangle_checker area_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cell_value(cell_value), .last_cell(last_cell),
		.out_valid(out_valid), .out_stall(out_stall), .largest_area(largest_area),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.errors(errors), .pending(pending)
	);

	// Receiver: a stall mode is redrawn each time mode_left runs out; a new hold_token asks for
	// one long hold-off so the unit backs up into its input.
	always @(negedge clk) begin
		static int hold_left = 0;
		static int hold_seen = 0;
		static int mode = 0;
		static int mode_left = 0;
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = LONG_HOLD;
		end
		if (mode_left == 0) begin
			mode = $urandom_range(3);
			mode_left = 64;
		end
		mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			out_stall = 1'b1;
		end else begin
			case (mode)
				0: out_stall = 1'b0;
				1: out_stall = ($urandom_range(99) < 30);
				2: out_stall = ~out_stall;
				default: out_stall = ($urandom_range(99) < 80);
			endcase
		end
	end

	// Watchdog: any transfer or register write resets the idle count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(psel && penable && pwrite && pready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int eff_dim(int v);
		if (v == 0) return 1;
		if (v > 128) return 128;
		return v;
	endfunction

	task automatic reg_write(logic sel, logic [7:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = (sel == lcr_pkg::REG_COL_COUNT) ? 3'd4 : 3'd0;
		pwdata = {16'($urandom_range(16'hffff, 0)), 8'($urandom), value};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		reg_writes++;
	endtask

	// One cell transfer; the sender works in bursts with random gaps between.
	task automatic send_cell(logic v, logic l);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
			repeat (gap) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid = 1'b1;
		cell_value = v;
		last_cell = l;
		do @(posedge clk); while (in_stall);
		cells_sent++;
	endtask

	// sender stops and waits out every expected area, then the solve tail
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_dims(logic [7:0] r, logic [7:0] c);
		drain();
		reg_write(lcr_pkg::REG_ROW_COUNT, r);
		reg_write(lcr_pkg::REG_COL_COUNT, c);
		rows_eff = eff_dim(r);
		cols_eff = eff_dim(c);
	endtask

	// One matrix of n transfers, last_cell on the final one. Content follows a
	// chessboard with the given flip rate, so large areas do occur.
	task automatic send_matrix(int n, int flip_pct);
		int k, total;
		logic phase;
		total = rows_eff * cols_eff;
		phase = 1'($urandom_range(1));
		for (k = 0; k < n; k++)
			send_cell(((k / cols_eff + k % cols_eff) % 2 == 1) ^ phase ^
				($urandom_range(99) < flip_pct), k == n-1);
		if (n > filled) filled = (n < total) ? n : total;
		if (n > total) surplus_runs++;
		if (n < total) early_runs++;
		matrices++;
	endtask

	initial begin
		int phase_no, m, nmat, total, n, sel, k;
		logic [7:0] r, c;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero counts read as one, single cells of each value
		set_dims(8'd0, 8'd0);
		send_cell(1'b0, 1'b1);
		send_cell(1'b1, 1'b1);
		filled = 1;
		// clean and flat 2x2
		set_dims(8'd2, 8'd2);
		send_matrix(4, 0);
		for (k = 0; k < 4; k++) send_cell(1'b1, k == 3);
		// 3x3 with surplus cells, then an early last cell over old content
		set_dims(8'd3, 8'd3);
		send_matrix(11, 0);
		send_matrix(2, 20);

		// random phases of settings; extremes mixed in
		phase_no = 0;
		while (cells_sent < ITEM_TARGET) begin
			sel = $urandom_range(9);
			case (sel)
				0: begin r = 8'd128; c = 8'($urandom_range(2, 1)); end
				1: begin r = 8'($urandom_range(2, 1)); c = 8'd128; end
				2: begin r = 8'd255; c = 8'd0; end
				3: begin r = 8'd0; c = 8'($urandom_range(255, 129)); end
				default: begin r = 8'($urandom_range(10, 1)); c = 8'($urandom_range(10, 1)); end
			endcase
			set_dims(r, c);
			total = rows_eff * cols_eff;
			nmat = $urandom_range(8, 3);
			// one long receiver hold-off while matrices keep coming
			if (phase_no == 3) hold_token++;
			for (m = 0; m < nmat && cells_sent < ITEM_TARGET; m++) begin
				k = $urandom_range(9);
				if (k == 0) n = total + $urandom_range(5, 1);
				else if (k == 1 && total > 1 && total <= filled) n = $urandom_range(total-1, 1);
				else n = total;
				send_matrix(n, $urandom_range(3) == 0 ? $urandom_range(40) : $urandom_range(8));
			end
			phase_no++;
		end

		drain();
		repeat (100) @(posedge clk);
		$display("tb: %0d cells in %0d matrices, %0d register writes", cells_sent, matrices,
			reg_writes);
		$display("tb: %0d matrices with surplus cells, %0d ended early", surplus_runs,
			early_runs);
		if (errors == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
`default_nettype wire
